@@ hw/rtl/prct_pkg.sv @@
// ----------------------------------------------------------------------------
// prct_pkg: shared types and constants of the rotation column tracker
// Payload structs, job classification, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package prct_pkg;

  // Angular resolution of the display
  localparam int NUM_COLUMNS = 256;
  localparam int COL_W       = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int HALF_COLS   = NUM_COLUMNS / 2;

  // elapsed * NUM_COLUMNS fits in 48 + COL_W bits; one quotient bit per step
  localparam int TIME_W = 48;
  localparam int PROD_W = TIME_W + COL_W;
  localparam int CNT_W  = $clog2(PROD_W);

  localparam int CFG_W = 24;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Reset values
  localparam logic [CFG_W-1:0]  MIN_PERIOD_RST    = 24'd10000;
  localparam logic [CFG_W-1:0]  ANIM_INTERVAL_RST = 24'd20000;
  localparam logic [TIME_W-1:0] TURN_PERIOD_RST   = 48'd3000000;

  // Configuration register indexes
  typedef enum logic {
    CFG_MIN_PERIOD    = 1'b0,
    CFG_ANIM_INTERVAL = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_period;
    logic [CFG_W-1:0] anim_interval;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic              edge_accepted;
    logic [TIME_W-1:0] measured_period;
    logic              column_new;
    logic [7:0]        column_index;
    logic [7:0]        mirror_column;
    logic              anim_step;
  } out_item_t;

  typedef enum logic {
    JOB_EDGE = 1'b0,
    JOB_POLL = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [TIME_W-1:0] now_us;
  } job_t;

  // Column half a turn away
  function automatic logic [COL_W-1:0] mirror_of(input logic [COL_W-1:0] col);
    logic [COL_W:0] sum;
    sum = {1'b0, col} + (COL_W+1)'(HALF_COLS);
    if (sum >= (COL_W+1)'(NUM_COLUMNS)) begin
      sum = sum - (COL_W+1)'(NUM_COLUMNS);
    end
    return sum[COL_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/prct_front.sv @@
// ----------------------------------------------------------------------------
// prct_front: input stage
// Accept input beats, classify them as edge or poll jobs, push to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module prct_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  prct_pkg::in_item_t   in_item,
  output logic                 push_valid,
  input  wire                  push_ready,
  output prct_pkg::job_t       push_job
);

  logic           front_valid_r;
  prct_pkg::job_t job_r;
  prct_pkg::job_t job_class;

  always_comb begin
    job_class.kind   = in_item.action ? prct_pkg::JOB_POLL : prct_pkg::JOB_EDGE;
    job_class.now_us = in_item.now_us;
  end

  // Take a new beat whenever the holding register is empty or empties this cycle
  assign in_ready   = !front_valid_r || push_ready;
  assign push_valid = front_valid_r;
  assign push_job   = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      front_valid_r <= 1'b1;
    end else if (push_ready) begin
      front_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r <= job_class;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/prct_queue.sv @@
// ----------------------------------------------------------------------------
// prct_queue: job queue
// Small FIFO of classified jobs between the front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none

module prct_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push_valid,
  output logic            push_ready,
  input  prct_pkg::job_t  push_job,
  output logic            pop_valid,
  input  wire             pop_ready,
  output prct_pkg::job_t  pop_job
);

  localparam int PTR_W = (prct_pkg::QUEUE_DEPTH > 1) ? $clog2(prct_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(prct_pkg::QUEUE_DEPTH + 1);

  prct_pkg::job_t   entries_r [prct_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(prct_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(prct_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/prct_back.sv @@
// ----------------------------------------------------------------------------
// prct_back: execution stage
// Hold the turn state, run edge jobs and the column divide, drive results.
// ----------------------------------------------------------------------------
`default_nettype none

module prct_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  prct_pkg::cfg_t      cfg,
  input  wire                 pop_valid,
  output logic                pop_ready,
  input  prct_pkg::job_t      pop_job,
  output logic                out_valid,
  input  wire                 out_ready,
  output prct_pkg::out_item_t out_item
);

  localparam int TW = prct_pkg::TIME_W;
  localparam int CW = prct_pkg::COL_W;
  localparam int PW = prct_pkg::PROD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  state_t                     state_r;
  logic [TW-1:0]              now_r;
  logic [TW-1:0]              turn_start_r;
  logic [TW-1:0]              turn_period_r;
  logic [CW-1:0]              prev_col_r;
  logic [TW-1:0]              anim_last_r;
  logic [PW-1:0]              dvd_r;
  logic [TW-1:0]              dsr_r;
  logic [TW-1:0]              rem_r;
  logic [CW-1:0]              col_r;
  logic [prct_pkg::CNT_W-1:0] cnt_r;
  logic                       anim_hit_r;
  prct_pkg::out_item_t        res_r;
  logic                       out_valid_r;
  prct_pkg::out_item_t        out_item_r;

  logic          edge_ge;
  logic [TW-1:0] edge_d;
  logic          edge_ok;
  logic [TW-1:0] elapsed;
  logic [PW-1:0] product;
  logic [TW:0]   anim_limit;
  logic          anim_hit;
  logic [TW:0]   rem_sh;
  logic          fits;
  logic [TW-1:0] rem_step;
  logic [CW:0]   col_sh;
  logic [CW-1:0] col_step;
  logic          out_free;
  logic          out_load;

  // Edge: period since the turn start, credible only above the minimum
  assign edge_ge = (pop_job.now_us >= turn_start_r);
  assign edge_d  = pop_job.now_us - turn_start_r;
  assign edge_ok = edge_ge && (edge_d > TW'(cfg.min_period));

  // Poll setup: elapsed time saturates at zero, then scale by the column count
  assign elapsed    = (now_r >= turn_start_r) ? now_r - turn_start_r : '0;
  assign product    = PW'(elapsed) * PW'(prct_pkg::NUM_COLUMNS);
  assign anim_limit = {1'b0, anim_last_r} + (TW+1)'(cfg.anim_interval);
  assign anim_hit   = ({1'b0, now_r} > anim_limit);

  // One restoring divide step; fold the quotient bit into quotient mod columns
  assign rem_sh   = {rem_r, dvd_r[PW-1]};
  assign fits     = (rem_sh >= {1'b0, dsr_r});
  assign rem_step = fits ? TW'(rem_sh - {1'b0, dsr_r}) : rem_sh[TW-1:0];
  assign col_sh   = {col_r, fits};
  assign col_step = (col_sh >= (CW+1)'(prct_pkg::NUM_COLUMNS)) ?
                    CW'(col_sh - (CW+1)'(prct_pkg::NUM_COLUMNS)) : col_sh[CW-1:0];

  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (state_r == S_DONE) && out_free;
  assign pop_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      turn_start_r  <= '0;
      turn_period_r <= prct_pkg::TURN_PERIOD_RST;
      prev_col_r    <= '0;
      anim_last_r   <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            if (pop_job.kind == prct_pkg::JOB_EDGE) begin
              if (edge_ok) begin
                turn_period_r <= edge_d;
                turn_start_r  <= pop_job.now_us;
              end
              res_r.edge_accepted   <= edge_ok;
              res_r.measured_period <= edge_ok ? edge_d : turn_period_r;
              res_r.column_new      <= 1'b0;
              res_r.column_index    <= 8'(prev_col_r);
              res_r.mirror_column   <= 8'(prct_pkg::mirror_of(prev_col_r));
              res_r.anim_step       <= 1'b0;
              state_r               <= S_DONE;
            end else begin
              now_r   <= pop_job.now_us;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          dvd_r      <= product;
          dsr_r      <= (turn_period_r == '0) ? TW'(1) : turn_period_r;
          rem_r      <= '0;
          col_r      <= '0;
          cnt_r      <= prct_pkg::CNT_W'(PW - 1);
          anim_hit_r <= anim_hit;
          state_r    <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_step;
          col_r <= col_step;
          dvd_r <= {dvd_r[PW-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          prev_col_r <= col_r;
          if (anim_hit_r) begin
            anim_last_r <= now_r;
          end
          res_r.edge_accepted   <= 1'b0;
          res_r.measured_period <= turn_period_r;
          res_r.column_new      <= (col_r != prev_col_r);
          res_r.column_index    <= 8'(col_r);
          res_r.mirror_column   <= 8'(prct_pkg::mirror_of(col_r));
          res_r.anim_step       <= anim_hit_r;
          state_r               <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_item_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pov_rotation_column_tracker.sv @@
// ----------------------------------------------------------------------------
// pov_rotation_column_tracker: angular column tracker for a spinning display
// An edge beat passes the front register, the queue and the back stage
//   on to the result register; a poll beat also runs the column divider
//   in the back stage, one quotient bit per cycle.
// The back stage holds one beat in flight at a time and takes the next job
//   from the queue only once it has returned to idle.
// Reset: synchronous active-low; clears the queue, the turn state and the
//   configuration registers to their defaults, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pov_rotation_column_tracker (
  input  wire                        clk,
  input  wire                        rst_n,
  // input channel
  input  wire                        in_valid,
  output logic                       in_ready,
  input  prct_pkg::in_item_t         in_item,
  // result channel
  output logic                       out_valid,
  input  wire                        out_ready,
  output prct_pkg::out_item_t        out_item,
  // configuration write channel
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  prct_pkg::cfg_index_t       cfg_index,
  input  wire [prct_pkg::CFG_W-1:0]  cfg_data
);

  // Configuration registers. Writes must arrive only while the block is idle;
  // the block does not enforce this. The back stage reads them directly, no shadow copy.
  prct_pkg::cfg_t cfg_r;

  logic           push_valid;
  logic           push_ready;
  prct_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  prct_pkg::job_t pop_job;

  // Every configuration beat is taken at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_period    <= prct_pkg::MIN_PERIOD_RST;
      cfg_r.anim_interval <= prct_pkg::ANIM_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        prct_pkg::CFG_MIN_PERIOD: begin
          cfg_r.min_period <= cfg_data;
        end
        prct_pkg::CFG_ANIM_INTERVAL: begin
          cfg_r.anim_interval <= cfg_data;
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Front: register the beat and tag it as an edge or a poll job
  prct_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Queue: decouple the front from the long divide in the back
  prct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Back: own the turn state, execute jobs in order, hold the result register
  prct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
